// ===== sv/obdq_pkg.sv =====
// ----------------------------------------------------------------------------
// obdq_pkg
// Shared types and constants of the diagnostic query transaction engine.
// ----------------------------------------------------------------------------
package obdq_pkg;

    localparam int IDENT_W   = 11;
    localparam int TICK_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int PAYLOAD_W = 64;
    localparam int LENGTH_W  = 4;
    localparam int KIND_W    = 2;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 144;

    localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
    localparam logic [OP_W-1:0] OP_FRAME = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_TX      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPLY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_ID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE_ID = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd3;

    localparam logic [IDENT_W-1:0] REQUEST_ID_RESET  = 11'h7DF;
    localparam logic [IDENT_W-1:0] RESPONSE_ID_RESET = 11'h7E8;
    localparam logic [TICK_W-1:0]  TIMEOUT_RESET     = 16'd1000;

    localparam logic [BYTE_W-1:0]   PCI_SINGLE_TWO = 8'h02;
    localparam logic [BYTE_W-1:0]   MODE01_REPLY   = 8'h41;
    localparam logic [LENGTH_W-1:0] MAX_LENGTH     = 4'd8;
    localparam logic [LENGTH_W-1:0] MIN_PID_LENGTH = 4'd3;
    localparam logic [IDENT_W-1:0]  REPLY_WINDOW   = 11'd2;
    localparam logic [TICK_W-1:0]   TICK_MAX       = 16'hFFFF;

    typedef struct packed {
        logic               enabled;
        logic [IDENT_W-1:0] request_id;
        logic [IDENT_W-1:0] response_base_id;
        logic [TICK_W-1:0]  timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic                waiting;
        logic [TICK_W-1:0]   elapsed_ticks;
        logic [BYTE_W-1:0]   pending_pid;
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [BYTE_W-1:0]    query_mode;
        logic [BYTE_W-1:0]    query_pid;
        logic [IDENT_W-1:0]   rx_ident;
        logic [LENGTH_W-1:0]  rx_length;
        logic [PAYLOAD_W-1:0] rx_payload;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [IDENT_W-1:0]   tx_ident;
        logic [PAYLOAD_W-1:0] tx_payload;
        logic [LENGTH_W-1:0]  reply_length;
        logic [PAYLOAD_W-1:0] reply_payload;
        logic                 pid_reply_ok;
    } result_t;

endpackage

// ===== sv/obd_query_transaction_engine_top.sv =====
// ----------------------------------------------------------------------------
// obd_query_transaction_engine_top
// Runs one diagnostic query at a time over 11-bit CAN: emits the request
// frame, matches the reply or reports a timeout.
//
//   Channel   Direction  Content
//   s_axis    in         tuser: operation; tdata: query item or received frame
//   m_axis    out        tuser: kind; tdata: transmit frame or reply report
//   cfg       in         register writes, one per cycle, no read-back
//
// One transaction per clock is accepted while the output is not stalled; each
// passes the input register, then its result (if any) the result register.
// The state update is a single compare-and-update between the two registers.
// A stalled output holds its result while the input register keeps one more
// transaction; ready then drops until the output is taken.
// Reset clears the query state and loads the register defaults.
// ----------------------------------------------------------------------------
module obd_query_transaction_engine_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    // tuser: operation[1:0]
    input  logic [obdq_pkg::OP_W-1:0]           s_tuser,
    // tdata: query_mode[7:0], query_pid[15:8], rx_ident[26:16],
    //        rx_length[30:27], rx_payload[94:31], zero pad[95]
    input  logic [obdq_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tuser: kind[1:0]
    output logic [obdq_pkg::KIND_W-1:0]         m_tuser,
    // tdata: tx_ident[10:0], tx_payload[74:11], reply_length[78:75],
    //        reply_payload[142:79], pid_reply_ok[143]
    output logic [obdq_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [obdq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [obdq_pkg::CFG_DATA_W-1:0]     cfg_data
);

    obdq_pkg::cfg_t    cfg_reg;
    obdq_pkg::state_t  state_reg;
    obdq_pkg::state_t  state_next;
    obdq_pkg::item_t   item_reg;
    obdq_pkg::result_t result_next;
    obdq_pkg::result_t result_reg;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              has_result;
    logic              advance;
    logic              in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    obdq_step u_step
    (
        .item       (item_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .has_result (has_result),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled          <= 1'b0;
            cfg_reg.request_id       <= obdq_pkg::REQUEST_ID_RESET;
            cfg_reg.response_base_id <= obdq_pkg::RESPONSE_ID_RESET;
            cfg_reg.timeout_ticks    <= obdq_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                obdq_pkg::CFG_ENABLED:
                    cfg_reg.enabled <= cfg_data[0];
                obdq_pkg::CFG_REQUEST_ID:
                    cfg_reg.request_id <= cfg_data[obdq_pkg::IDENT_W-1:0];
                obdq_pkg::CFG_RESPONSE_ID:
                    cfg_reg.response_base_id <= cfg_data[obdq_pkg::IDENT_W-1:0];
                obdq_pkg::CFG_TIMEOUT:
                    cfg_reg.timeout_ticks <= cfg_data[obdq_pkg::TICK_W-1:0];
                default:
                    cfg_reg.enabled <= cfg_reg.enabled;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= has_result;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.operation  <= s_tuser;
            item_reg.query_mode <= s_tdata[7:0];
            item_reg.query_pid  <= s_tdata[15:8];
            item_reg.rx_ident   <= s_tdata[26:16];
            item_reg.rx_length  <= s_tdata[30:27];
            item_reg.rx_payload <= s_tdata[94:31];
        end
        if (advance && has_result)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.kind;
    assign m_tdata  = {result_reg.pid_reply_ok, result_reg.reply_payload,
                       result_reg.reply_length, result_reg.tx_payload,
                       result_reg.tx_ident};

endmodule

// ===== sv/obdq_step.sv =====
// ----------------------------------------------------------------------------
// obdq_step
// Combinational update of the query state for one item and its result.
// ----------------------------------------------------------------------------
module obdq_step
(
    input  obdq_pkg::item_t   item,
    input  obdq_pkg::cfg_t    cfg,
    input  obdq_pkg::state_t  state,
    output obdq_pkg::state_t  state_next,
    output logic              has_result,
    output obdq_pkg::result_t result
);

    logic [obdq_pkg::IDENT_W:0]    id_diff;
    logic                          id_match;
    logic [obdq_pkg::LENGTH_W-1:0] len_clamped;
    logic [obdq_pkg::PAYLOAD_W-1:0] masked_payload;
    logic [obdq_pkg::TICK_W-1:0]   elapsed_inc;

    always_comb
    begin
        id_diff  = {1'b0, item.rx_ident} - {1'b0, cfg.response_base_id};
        id_match = !id_diff[obdq_pkg::IDENT_W]
                   && (id_diff[obdq_pkg::IDENT_W-1:0] <= obdq_pkg::REPLY_WINDOW);

        len_clamped = (item.rx_length > obdq_pkg::MAX_LENGTH) ? obdq_pkg::MAX_LENGTH
                                                               : item.rx_length;
        for (int i = 0; i < 8; i++)
        begin
            masked_payload[i*obdq_pkg::BYTE_W +: obdq_pkg::BYTE_W] =
                (obdq_pkg::LENGTH_W'(i) < len_clamped)
                ? item.rx_payload[i*obdq_pkg::BYTE_W +: obdq_pkg::BYTE_W]
                : '0;
        end

        elapsed_inc = (state.elapsed_ticks == obdq_pkg::TICK_MAX)
                      ? state.elapsed_ticks
                      : state.elapsed_ticks + obdq_pkg::TICK_W'(1);
    end

    always_comb
    begin
        state_next = state;
        has_result = 1'b0;
        result     = '0;
        case (item.operation)
            obdq_pkg::OP_QUERY:
            begin
                has_result = 1'b1;
                if (!cfg.enabled || state.waiting)
                begin
                    result.kind = obdq_pkg::KIND_REFUSED;
                end
                else
                begin
                    state_next.waiting       = 1'b1;
                    state_next.elapsed_ticks = '0;
                    state_next.pending_pid   = item.query_pid;
                    result.kind       = obdq_pkg::KIND_TX;
                    result.tx_ident   = cfg.request_id;
                    result.tx_payload = {40'd0, item.query_pid, item.query_mode,
                                         obdq_pkg::PCI_SINGLE_TWO};
                end
            end
            obdq_pkg::OP_FRAME:
            begin
                if (state.waiting && id_match)
                begin
                    state_next.waiting   = 1'b0;
                    has_result           = 1'b1;
                    result.kind          = obdq_pkg::KIND_REPLY;
                    result.reply_length  = len_clamped;
                    result.reply_payload = masked_payload;
                    result.pid_reply_ok  = (len_clamped >= obdq_pkg::MIN_PID_LENGTH)
                                           && (masked_payload[15:8] == obdq_pkg::MODE01_REPLY)
                                           && (masked_payload[23:16] == state.pending_pid);
                end
            end
            obdq_pkg::OP_TICK:
            begin
                if (state.waiting)
                begin
                    state_next.elapsed_ticks = elapsed_inc;
                    if (elapsed_inc >= cfg.timeout_ticks)
                    begin
                        state_next.waiting = 1'b0;
                        has_result         = 1'b1;
                        result.kind        = obdq_pkg::KIND_TIMEOUT;
                    end
                end
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/obdq_checker.sv =====
// ----------------------------------------------------------------------------
// obdq_checker
// Port-level checks of the diagnostic query transaction engine.
// ----------------------------------------------------------------------------
module obdq_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic [obdq_pkg::KIND_W-1:0]     m_tuser,
    input logic [obdq_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready
);

    a_tx_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != obdq_pkg::KIND_TX) |-> (m_tdata[74:0] == '0))
        else $error("transmit fields set on a non-transmit result");

    a_tx_frame_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == obdq_pkg::KIND_TX)
        |-> (m_tdata[18:11] == obdq_pkg::PCI_SINGLE_TWO && m_tdata[74:35] == '0
             && m_tdata[143:75] == '0))
        else $error("malformed transmit frame");

    a_reply_length: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == obdq_pkg::KIND_REPLY)
        |-> (m_tdata[78:75] <= obdq_pkg::MAX_LENGTH))
        else $error("reply length above eight");

    a_pid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[143])
        |-> (m_tuser == obdq_pkg::KIND_REPLY && m_tdata[78:75] >= obdq_pkg::MIN_PID_LENGTH
             && m_tdata[94:87] == obdq_pkg::MODE01_REPLY))
        else $error("pid reply flag without a valid mode 01 reply");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule

bind obd_query_transaction_engine_top obdq_checker u_obdq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
